### hdl/cgcc_pkg.sv
`timescale 1ns / 1ps

package cgcc_pkg;

    localparam int ROW_COUNT   = 16;
    localparam int GROUP_COUNT = 8;
    localparam int AXIS_COUNT  = 4;
    localparam int COORD_BITS  = 32;

    // Coordinate fields carried by one beat.
    localparam int AXIS_SLOTS = 4;
    localparam int FIELD_BITS = 32;
    // Significant bits of a coordinate or threshold.
    localparam int CMP_BITS = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
    localparam int SEXT_SHIFT = FIELD_BITS - CMP_BITS;
    // Only groups that fit the 3-bit group code are examined.
    localparam int GROUPS_EXAMINED = (GROUP_COUNT < 8) ? GROUP_COUNT : 8;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_CHECK = 1'b1;

    localparam logic [2:0] REL_EQ = 3'd0;
    localparam logic [2:0] REL_GE = 3'd1;
    localparam logic [2:0] REL_LE = 3'd2;
    localparam logic [2:0] REL_GT = 3'd3;
    localparam logic [2:0] REL_LT = 3'd4;

    typedef logic signed [FIELD_BITS-1:0] coord_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] group;
        logic [2:0] axis;
        logic [2:0] relation;
        coord_t     threshold;
    } row_t;

    typedef struct packed {
        logic       veto;
        logic [2:0] group;
    } lane_flag_t;

    function automatic coord_t cc_sext(input logic [FIELD_BITS-1:0] v);
        coord_t shifted;
        shifted = coord_t'(v << SEXT_SHIFT);
        return shifted >>> SEXT_SHIFT;
    endfunction

endpackage

### hdl/cgcc_lane.sv
`timescale 1ns / 1ps

module cgcc_lane
    import cgcc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr_en,
    input  row_t       wr_row,
    input  coord_t     coords [AXIS_SLOTS],
    output lane_flag_t flag
);

    row_t row_reg;
    row_t row_next;
    logic ok;
    coord_t p;

    always_comb begin
        row_next = row_reg;
        if (wr_en) begin
            row_next = wr_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg.valid <= 1'b0;
        end else begin
            row_reg.valid <= row_next.valid;
        end
        row_reg.group     <= row_next.group;
        row_reg.axis      <= row_next.axis;
        row_reg.relation  <= row_next.relation;
        row_reg.threshold <= row_next.threshold;
    end

    always_comb begin
        p  = coords[row_reg.axis[1:0]];
        ok = 1'b0;
        if ((int'(row_reg.axis) < AXIS_COUNT) && (int'(row_reg.axis) < AXIS_SLOTS)) begin
            unique case (row_reg.relation)
                REL_EQ:  ok = (p == row_reg.threshold);
                REL_GE:  ok = (p >= row_reg.threshold);
                REL_LE:  ok = (p <= row_reg.threshold);
                REL_GT:  ok = (p >  row_reg.threshold);
                REL_LT:  ok = (p <  row_reg.threshold);
                default: ok = 1'b0;
            endcase
        end
        flag.veto  = row_reg.valid && !ok;
        flag.group = row_reg.group;
    end

endmodule

### hdl/cgcc_merge.sv
`timescale 1ns / 1ps

module cgcc_merge
    import cgcc_pkg::*;
(
    input  lane_flag_t flags [ROW_COUNT],
    input  logic [7:0] groups_in_use,
    output logic       hit,
    output logic [2:0] hit_group
);

    logic [7:0] fail;

    always_comb begin
        fail = '0;
        for (int g = 0; g < 8; g++) begin
            for (int r = 0; r < ROW_COUNT; r++) begin
                if (flags[r].veto && (int'(flags[r].group) == g)) begin
                    fail[g] = 1'b1;
                end
            end
        end
    end

    // Walk from the top group down so that the lowest qualifying group wins.
    always_comb begin
        hit       = 1'b0;
        hit_group = '0;
        for (int g = GROUPS_EXAMINED - 1; g >= 0; g--) begin
            if (groups_in_use[g] && !fail[g]) begin
                hit       = 1'b1;
                hit_group = 3'(g);
            end
        end
    end

endmodule

### hdl/constraint_group_collision_check.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    mode, coord_0..3, row_slot/enable/group/axis,
//                                           row_relation, row_threshold
// m_        out        m_valid / m_ready    collision, hit_group, write_done
// cfg_      in         cfg_wr_en            cfg_wr_data (groups_in_use)
//
// Every beat, row write or point check, ends in the output register: one row lane per table slot
// compares its threshold against the selected coordinate, and for a point check the merge stage
// folds the lane results into the output register.
// One beat is accepted per cycle while the output register is free or being drained.
// A stall on m_ready holds the result and deasserts s_ready.
// Reset (aresetn low, synchronous) invalidates every row and clears groups_in_use.

module constraint_group_collision_check
    import cgcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic signed [31:0] s_coord_0,
    input  logic signed [31:0] s_coord_1,
    input  logic signed [31:0] s_coord_2,
    input  logic signed [31:0] s_coord_3,
    input  logic [3:0]  s_row_slot,
    input  logic        s_row_enable,
    input  logic [2:0]  s_row_group,
    input  logic [2:0]  s_row_axis,
    input  logic [2:0]  s_row_relation,
    input  logic signed [31:0] s_row_threshold,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_collision,
    output logic [2:0]  m_hit_group,
    output logic        m_write_done
);

    logic [7:0] groups_in_use_reg;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       collision_reg;
    logic [2:0] hit_group_reg;
    logic       write_done_reg;

    logic       accept;
    coord_t     coords [AXIS_SLOTS];
    row_t       wr_row;
    lane_flag_t flags [ROW_COUNT];
    logic       hit;
    logic [2:0] hit_grp;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign coords[0] = cc_sext(s_coord_0);
    assign coords[1] = cc_sext(s_coord_1);
    assign coords[2] = cc_sext(s_coord_2);
    assign coords[3] = cc_sext(s_coord_3);

    always_comb begin
        wr_row.valid     = s_row_enable;
        wr_row.group     = s_row_group;
        wr_row.axis      = s_row_axis;
        wr_row.relation  = s_row_relation;
        wr_row.threshold = cc_sext(s_row_threshold);
    end

    for (genvar r = 0; r < ROW_COUNT; r++) begin : g_lane
        cgcc_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .wr_en   (accept && (s_mode == MODE_WRITE) && (int'(s_row_slot) == r)),
            .wr_row  (wr_row),
            .coords  (coords),
            .flag    (flags[r])
        );
    end

    cgcc_merge u_merge (
        .flags         (flags),
        .groups_in_use (groups_in_use_reg),
        .hit           (hit),
        .hit_group     (hit_grp)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_ready) begin
            m_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg       <= 1'b0;
            groups_in_use_reg <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                groups_in_use_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            collision_reg  <= (s_mode == MODE_CHECK) && hit;
            hit_group_reg  <= (s_mode == MODE_CHECK) ? hit_grp : 3'd0;
            write_done_reg <= (s_mode == MODE_WRITE);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_collision  = collision_reg;
    assign m_hit_group  = hit_group_reg;
    assign m_write_done = write_done_reg;

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_write_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_mode == MODE_WRITE)) |=>
            (m_valid && m_write_done && !m_collision && (m_hit_group == 3'd0)))
        else $error("row write beat gave a wrong result");

    a_check_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_mode == MODE_CHECK)) |=> (m_valid && !m_write_done))
        else $error("point check beat gave a wrong result");

    a_no_hit_group: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_collision) |-> (m_hit_group == 3'd0))
        else $error("hit group set without a collision");

endmodule
